// ----- sv/lph_pkg.sv -----
// shared types and codes for the linear probing hash table
`default_nettype none

package lph_pkg;

    // request operation codes
    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_GET    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // slot state kept in the tag store
    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_USED  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    // fixed field widths of the channels
    localparam int HASH_W  = 32;
    localparam int KEYIN_W = 64;
    localparam int LEN_W   = 4;
    localparam int VALUE_W = 64;
    localparam int SLOT_W  = 10;
    localparam int CAP_IN_W = 11;

endpackage

`default_nettype wire

// ----- sv/lph_req_if.sv -----
// request channel: operation, key and value
`default_nettype none

interface lph_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] key_hash;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [63:0] value_in;

    modport source (
        output valid, func, key_hash, key_bytes, key_len, value_in,
        input  ready
    );
    modport sink (
        input  valid, func, key_hash, key_bytes, key_len, value_in,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/lph_rsp_if.sv -----
// response channel: status, value and slot
`default_nettype none

interface lph_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] value_out;
    logic [9:0]  slot_index;

    modport source (
        output valid, status, value_out, slot_index,
        input  ready
    );
    modport sink (
        input  valid, status, value_out, slot_index,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/lph_store.sv -----
// slot tag memory and slot entry memory, one write and one registered read port
`default_nettype none

module lph_store
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_W      = 164,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic              tag_we,
    input  wire tag_t              tag_wdata,
    input  wire logic              data_we,
    input  wire logic [DATA_W-1:0] data_wdata,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output tag_t                   rd_tag,
    output logic [DATA_W-1:0]      rd_data
);

    tag_t              tag_mem  [TABLE_DEPTH];
    logic [DATA_W-1:0] data_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= tag_wdata;
        end
        rd_tag <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[wr_addr] <= data_wdata;
        end
        rd_data <= data_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/linear_probe_hash_table.sv -----
// top level of the key-value table with linear probing and tombstones
// usage:
//   req carries one transaction per operation (put, get, remove) with the key
//   hash, up to KEY_BYTES key bytes, the key length and a value; rsp returns
//   one transaction per request with status, value and slot index
//   cfg_we with cfg_wdata sets the number of slots in use (saturated to
//   TABLE_DEPTH) and empties the table; write it only while the block is idle
// timing:
//   after acceptance the block computes the home slot (one cycle), then walks
//   slots at two cycles per probe (memory read, then compare), then one cycle
//   to hand over the result: latency 2 + 2*p cycles for p probes, with p = 0
//   when the request is refused at once (full table, no slots, bad func)
//   one request in flight at a time, so a new one is taken every 3 + 2*p
//   cycles; the probe walk sets the rate, a few probes on average below 3/4 load
// reset and clearing:
//   reset and every capacity write start a pass that marks all TABLE_DEPTH
//   slots empty, one per cycle; req is not ready during those cycles
// stalls:
//   the response sits in an output register; while rsp is stalled the next
//   request is still taken and worked on, and it waits only at hand-over
`default_nettype none

module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    lph_req_if.sink                  req,
    lph_rsp_if.source                rsp,
    input  wire logic                cfg_we,
    input  wire logic [CAP_IN_W-1:0] cfg_wdata
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);        // capacity and count width
    localparam int LW     = CW + 3;                          // load limit arithmetic
    localparam int CMP_W  = (CW > CAP_IN_W) ? CW : CAP_IN_W;
    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int DATA_W = HASH_W + KEY_W + LEN_W + VALUE_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     clr_idx_reg;
    logic [CW-1:0]        capacity_reg;
    logic [CW-1:0]        capacity_next;
    logic [CW-1:0]        count_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CW-1:0]        probe_n_reg;
    logic                 have_tomb_reg;
    logic [IDX_W-1:0]     tomb_reg;

    // request held for the duration of the walk
    logic [1:0]           func_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [VALUE_W-1:0]   value_reg;

    // finished result and output register
    logic [1:0]           res_status_reg;
    logic [VALUE_W-1:0]   res_value_reg;
    logic [IDX_W-1:0]     res_slot_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 hand_over;

    // memory ports
    logic [IDX_W-1:0]     wr_addr;
    logic                 tag_we;
    tag_t                 tag_wdata;
    logic                 data_we;
    logic [DATA_W-1:0]    data_wdata;
    tag_t                 rd_tag;
    logic [DATA_W-1:0]    rd_data;

    // fields of the slot just read
    logic [HASH_W-1:0]    rd_hash;
    logic [KEY_W-1:0]     rd_key;
    logic [LEN_W-1:0]     rd_len;
    logic [VALUE_W-1:0]   rd_value;
    logic [KEY_BYTES-1:0] byte_ok;
    logic                 rd_match;

    // probe step decisions
    logic                 walk_last;
    logic [CW-1:0]        idx_inc;
    logic [IDX_W-1:0]     idx_step;
    logic                 tomb_seen;
    logic [IDX_W-1:0]     tomb_at;
    logic                 fin;
    logic [1:0]           fin_status;
    logic [VALUE_W-1:0]   fin_value;
    logic [IDX_W-1:0]     fin_slot;
    logic                 count_inc;

    // home slot and load limit
    logic [HASH_W+CW-1:0] home_prod;
    logic [LW-1:0]        load_need;
    logic [LW-1:0]        load_limit;
    logic                 over_load;
    logic [CMP_W-1:0]     cfg_ext;

    lph_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_W      (DATA_W)
    ) u_store (
        .clk        (clk),
        .wr_addr    (wr_addr),
        .tag_we     (tag_we),
        .tag_wdata  (tag_wdata),
        .data_we    (data_we),
        .data_wdata (data_wdata),
        .rd_addr    (idx_reg),
        .rd_tag     (rd_tag),
        .rd_data    (rd_data)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.value_out  = out_value_reg;
    assign rsp.slot_index = out_slot_reg;

    // result moves to the output register once that register is free
    assign hand_over = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // capacity written saturates at the table depth
    assign cfg_ext       = CMP_W'(cfg_wdata);
    assign capacity_next = (cfg_ext > DEPTH_C) ? CW'(DEPTH_C) : CW'(cfg_ext);

    // home slot is the top word of hash times capacity
    assign home_prod = HASH_W'(hash_reg) * (HASH_W + CW)'(capacity_reg);

    // put is refused when 4*(count+1) > 3*capacity
    assign load_need  = (LW'(count_reg) + LW'(1)) << 2;
    assign load_limit = (LW'(capacity_reg) << 1) + LW'(capacity_reg);
    assign over_load  = (load_need > load_limit);

    assign {rd_hash, rd_key, rd_len, rd_value} = rd_data;

    // a key byte counts only below the requested length
    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            byte_ok[b] = (LEN_W'(b) >= len_reg) || (rd_key[8*b +: 8] == key_reg[8*b +: 8]);
        end
    end

    assign rd_match = (rd_tag == TAG_USED) && (rd_hash == hash_reg) &&
                      (rd_len == len_reg) && (&byte_ok);

    // forward step with wrap at capacity
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign idx_step  = (idx_inc == capacity_reg) ? '0 : IDX_W'(idx_inc);
    assign walk_last = ((probe_n_reg + CW'(1)) == capacity_reg);
    assign tomb_seen = have_tomb_reg || (rd_tag == TAG_TOMB);
    assign tomb_at   = have_tomb_reg ? tomb_reg : idx_reg;

    // memory writes and the outcome of one probe
    always_comb
    begin
        tag_we     = 1'b0;
        tag_wdata  = TAG_EMPTY;
        data_we    = 1'b0;
        data_wdata = {hash_reg, key_reg, len_reg, value_reg};
        wr_addr    = idx_reg;
        fin        = 1'b0;
        fin_status = ST_MISSING;
        fin_value  = '0;
        fin_slot   = '0;
        count_inc  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                tag_we  = 1'b1;
                wr_addr = clr_idx_reg;
            end
            S_CHECK:
            begin
                if (rd_match)
                begin
                    fin        = 1'b1;
                    fin_status = ST_OK;
                    fin_slot   = idx_reg;
                    case (func_reg)
                        FUNC_PUT:
                        begin
                            tag_we    = 1'b1;
                            tag_wdata = TAG_USED;
                            data_we   = 1'b1;
                        end
                        FUNC_GET:
                        begin
                            fin_value = rd_value;
                        end
                        default:
                        begin
                            tag_we    = 1'b1;
                            tag_wdata = TAG_TOMB;
                        end
                    endcase
                end
                else if (rd_tag == TAG_EMPTY)
                begin
                    fin = 1'b1;
                    if (func_reg == FUNC_PUT)
                    begin
                        // reuse the first tombstone passed, else take this slot
                        wr_addr    = have_tomb_reg ? tomb_reg : idx_reg;
                        tag_we     = 1'b1;
                        tag_wdata  = TAG_USED;
                        data_we    = 1'b1;
                        fin_status = ST_OK;
                        fin_slot   = wr_addr;
                        count_inc  = !have_tomb_reg;
                    end
                end
                else if (walk_last)
                begin
                    // whole ring walked without an empty slot
                    fin = 1'b1;
                    if ((func_reg == FUNC_PUT) && tomb_seen)
                    begin
                        wr_addr    = tomb_at;
                        tag_we     = 1'b1;
                        tag_wdata  = TAG_USED;
                        data_we    = 1'b1;
                        fin_status = ST_OK;
                        fin_slot   = tomb_at;
                    end
                    else if (func_reg == FUNC_PUT)
                    begin
                        fin_status = ST_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, walk state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            capacity_reg  <= CW'(TABLE_DEPTH);
            count_reg     <= '0;
            idx_reg       <= '0;
            probe_n_reg   <= '0;
            have_tomb_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (hand_over)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_value_reg  <= res_value_reg;
                out_slot_reg   <= SLOT_W'(res_slot_reg);
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // a capacity write empties the table through a new clearing pass
            if (cfg_we)
            begin
                capacity_reg <= capacity_next;
                count_reg    <= '0;
                clr_idx_reg  <= '0;
                state_reg    <= S_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                        if (clr_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (req.valid)
                        begin
                            func_reg  <= req.func;
                            hash_reg  <= req.key_hash;
                            key_reg   <= KEY_W'(req.key_bytes);
                            len_reg   <= req.key_len;
                            value_reg <= req.value_in;
                            state_reg <= S_HOME;
                        end
                    end
                    S_HOME:
                    begin
                        idx_reg        <= home_prod[HASH_W +: IDX_W];
                        probe_n_reg    <= '0;
                        have_tomb_reg  <= 1'b0;
                        res_status_reg <= ST_MISSING;
                        res_value_reg  <= '0;
                        res_slot_reg   <= '0;
                        if ((func_reg != FUNC_PUT) && (func_reg != FUNC_GET) &&
                            (func_reg != FUNC_REMOVE))
                        begin
                            state_reg <= S_DONE;
                        end
                        else if ((func_reg == FUNC_PUT) && over_load)
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else if (capacity_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                    S_READ:
                    begin
                        state_reg <= S_CHECK;
                    end
                    S_CHECK:
                    begin
                        if (fin)
                        begin
                            res_status_reg <= fin_status;
                            res_value_reg  <= fin_value;
                            res_slot_reg   <= fin_slot;
                            if (count_inc)
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            if ((rd_tag == TAG_TOMB) && !have_tomb_reg)
                            begin
                                have_tomb_reg <= 1'b1;
                                tomb_reg      <= idx_reg;
                            end
                            idx_reg     <= idx_step;
                            probe_n_reg <= probe_n_reg + CW'(1);
                            state_reg   <= S_READ;
                        end
                    end
                    S_DONE:
                    begin
                        // hand over once the output register is free
                        if (hand_over)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_linear_probe_hash_table.sv -----
// self-checking testbench for the linear probing key-value table, directed rows then random phases
`timescale 1ns / 100ps

module tb_linear_probe_hash_table
    import lph_pkg::*;
();

    localparam int TABLE_DEPTH      = 1024;
    localparam int KEY_BYTES        = 8;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int N_PHASES         = 8;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int POOL_DEPTH       = 64;
    // long receiver hold-off, well past what the output register can absorb
    localparam int HOLD_CYCLES      = 400;
    // worst single transaction: a walk over every slot plus hand-over
    localparam int DRAIN_CYCLES     = 2 * TABLE_DEPTH + 8;
    localparam int TIMEOUT_NS       = 150_000_000;

    localparam logic [63:0] ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    // the one func code that the block does not decode
    localparam logic [1:0]  FUNC_BAD = 2'd3;

    // capacity per random phase: full depth, small, tiny, saturating and odd sizes
    localparam logic [CAP_IN_W-1:0] PHASE_CAP [N_PHASES] =
        '{11'd1024, 11'd16, 11'd64, 11'd1, 11'd2047, 11'd7, 11'd300, 11'd2};

    typedef struct packed {
        logic [1:0]         func;
        logic [HASH_W-1:0]  hash;
        logic [KEYIN_W-1:0] key;
        logic [LEN_W-1:0]   len;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  slot;
    } response_t;

    // one row of the directed part: either a capacity write or a request
    typedef struct {
        bit                  set_cap;
        logic [CAP_IN_W-1:0] cap;
        request_t            rq;
        bit                  typed;
        response_t           want;
    } dir_row_t;

    // a key that random requests can come back to
    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [KEYIN_W-1:0] key;
        logic [LEN_W-1:0]   len;
    } key_ref_t;

    typedef enum int { WALK_NONE, WALK_MATCH, WALK_FREE } walk_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CAP_IN_W-1:0] cfg_wdata;

    lph_req_if req_bus ();
    lph_rsp_if rsp_bus ();

    // shadow copy of the slot store and the occupancy count
    tag_t               shadow_tag   [TABLE_DEPTH];
    logic [HASH_W-1:0]  shadow_hash  [TABLE_DEPTH];
    logic [KEYIN_W-1:0] shadow_key   [TABLE_DEPTH];
    logic [LEN_W-1:0]   shadow_len   [TABLE_DEPTH];
    logic [VALUE_W-1:0] shadow_value [TABLE_DEPTH];
    int unsigned        shadow_cap;
    int unsigned        shadow_count;

    response_t   pending_rsp [$];
    dir_row_t    directed_rows [$];
    key_ref_t    key_pool [$];
    logic [7:0]  cluster_base;

    // idling knobs, written by the stimulus process only
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_token;

    int unsigned n_requests;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_cfg_writes;
    int unsigned n_status [4];

    linear_probe_hash_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // a capacity write saturates at the depth and empties every slot
    function automatic void clear_shadow(input logic [CAP_IN_W-1:0] cap_wr);
        shadow_cap = (cap_wr > TABLE_DEPTH) ? TABLE_DEPTH : cap_wr;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_tag[i] = TAG_EMPTY;
        shadow_count = 0;
    endfunction

    // linear walk from the home slot; on a free outcome the first tombstone
    // passed wins over the empty slot that stopped the walk
    function automatic walk_t walk_slots(input request_t rq, output int unsigned where);
        logic [63:0] product;
        logic [63:0] mask;
        int unsigned idx;
        int unsigned n_bytes;
        bit          seen_tomb;
        int unsigned tomb_idx;
        where     = 0;
        seen_tomb = 1'b0;
        tomb_idx  = 0;
        if (shadow_cap == 0)
            return WALK_NONE;
        n_bytes = (rq.len > KEY_BYTES) ? KEY_BYTES : rq.len;
        mask    = (n_bytes >= 8) ? ONES : ((64'd1 << (8 * n_bytes)) - 64'd1);
        // home slot by multiply and shift of the hash
        product = 64'(rq.hash) * 64'(shadow_cap);
        idx     = product[63:32];
        for (int unsigned n = 0; n < shadow_cap; n++)
        begin
            if (shadow_tag[idx] == TAG_EMPTY)
            begin
                where = seen_tomb ? tomb_idx : idx;
                return WALK_FREE;
            end
            if (shadow_tag[idx] == TAG_TOMB)
            begin
                if (!seen_tomb)
                begin
                    seen_tomb = 1'b1;
                    tomb_idx  = idx;
                end
            end
            else if (shadow_hash[idx] == rq.hash && shadow_len[idx] == rq.len &&
                     ((shadow_key[idx] ^ rq.key) & mask) == 64'd0)
            begin
                where = idx;
                return WALK_MATCH;
            end
            idx = (idx + 1 == shadow_cap) ? 0 : idx + 1;
        end
        // a whole lap without an empty slot
        if (seen_tomb)
        begin
            where = tomb_idx;
            return WALK_FREE;
        end
        return WALK_NONE;
    endfunction

    // updates the shadow store for one request and returns its response
    function automatic response_t apply_request(input request_t rq);
        response_t   rsp;
        walk_t       outcome;
        int unsigned where;
        rsp        = '0;
        rsp.status = ST_MISSING;
        case (rq.func)
            FUNC_PUT:
            begin
                // load limit of three quarters, checked before any walk
                if (4 * (shadow_count + 1) > 3 * shadow_cap)
                    rsp.status = ST_FULL;
                else
                begin
                    outcome = walk_slots(rq, where);
                    if (outcome == WALK_NONE)
                        rsp.status = ST_FULL;
                    else
                    begin
                        if (outcome == WALK_FREE && shadow_tag[where] == TAG_EMPTY)
                            shadow_count++;
                        shadow_tag[where]   = TAG_USED;
                        shadow_hash[where]  = rq.hash;
                        shadow_key[where]   = rq.key;
                        shadow_len[where]   = rq.len;
                        shadow_value[where] = rq.value;
                        rsp.status = ST_OK;
                        rsp.slot   = SLOT_W'(where);
                    end
                end
            end
            FUNC_GET, FUNC_REMOVE:
            begin
                outcome = walk_slots(rq, where);
                if (outcome == WALK_MATCH)
                begin
                    rsp.status = ST_OK;
                    rsp.slot   = SLOT_W'(where);
                    if (rq.func == FUNC_GET)
                        rsp.value = shadow_value[where];
                    else
                        shadow_tag[where] = TAG_TOMB;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // random request: mostly keys already put, some fresh ones, a little noise
    function automatic request_t random_request();
        request_t    rq;
        key_ref_t    kr;
        int unsigned pick;
        int unsigned n_bytes;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            rq.func = FUNC_BAD;
        else if (pick < 48)
            rq.func = FUNC_PUT;
        else if (pick < 76)
            rq.func = FUNC_GET;
        else
            rq.func = FUNC_REMOVE;
        rq.value = {$urandom, $urandom};
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 70)
        begin
            kr = key_pool[$urandom_range(0, key_pool.size() - 1)];
            // same hash and length with one bit changed: a near miss, or a
            // hit when the bit lies past the key length
            if ($urandom_range(0, 19) == 0)
                kr.key = kr.key ^ (64'd1 << $urandom_range(0, 63));
        end
        else
        begin
            // half spread over the whole range, half packed into a narrow
            // band of home slots so that probe chains grow long
            if ($urandom_range(0, 1) == 0)
                kr.hash = $urandom;
            else
                kr.hash = {cluster_base + 8'($urandom_range(0, 3)), 24'($urandom)};
            if ($urandom_range(0, 9) == 0)
                kr.len = 4'($urandom_range(KEY_BYTES + 1, 15));
            else
                kr.len = 4'($urandom_range(0, KEY_BYTES));
            n_bytes = (kr.len > KEY_BYTES) ? KEY_BYTES : kr.len;
            kr.key  = {$urandom, $urandom};
            // unused bytes are normally zero, now and then left dirty
            if (n_bytes < 8 && $urandom_range(0, 19) != 0)
                kr.key = kr.key & ((64'd1 << (8 * n_bytes)) - 64'd1);
            if (rq.func == FUNC_PUT)
            begin
                key_pool.push_back(kr);
                if (key_pool.size() > POOL_DEPTH)
                    void'(key_pool.pop_front());
            end
        end
        rq.hash = kr.hash;
        rq.key  = kr.key;
        rq.len  = kr.len;
        return rq;
    endfunction

    function automatic void cfg_row(input logic [CAP_IN_W-1:0] cap);
        dir_row_t r;
        r         = '{default: '0};
        r.set_cap = 1'b1;
        r.cap     = cap;
        directed_rows.push_back(r);
    endfunction

    // typed rows carry their response; the rest are left to the predictor
    function automatic void req_row(input bit typed, input logic [1:0] func,
                                    input logic [31:0] hash, input logic [63:0] key,
                                    input logic [3:0] len, input logic [63:0] value,
                                    input logic [1:0] status, input logic [63:0] vout,
                                    input logic [9:0] slot);
        dir_row_t r;
        r             = '{default: '0};
        r.rq          = '{func: func, hash: hash, key: key, len: len, value: value};
        r.typed       = typed;
        r.want.status = status;
        r.want.value  = vout;
        r.want.slot   = slot;
        directed_rows.push_back(r);
    endfunction

    function automatic void check_field(input string label, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
            n_errors++;
        end
    endfunction

    // waits for the block to go idle, then writes the capacity register
    task automatic write_capacity(input logic [CAP_IN_W-1:0] cap_wr);
        req_bus.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        cfg_wdata = cap_wr;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        clear_shadow(cap_wr);
        n_cfg_writes++;
    endtask

    // offers one request from a falling edge and returns at the falling edge
    // after acceptance, with valid still high for a back-to-back transaction
    task automatic send_request(input request_t rq, input bit typed, input response_t want);
        response_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.func      = rq.func;
        req_bus.key_hash  = rq.hash;
        req_bus.key_bytes = rq.key;
        req_bus.key_len   = rq.len;
        req_bus.value_in  = rq.value;
        req_bus.valid     = 1'b1;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        // accepted at this edge: predict in acceptance order
        predicted = apply_request(rq);
        pending_rsp.push_back(typed ? want : predicted);
        n_requests++;
        @(negedge clk);
    endtask

    // response side: random stalls, plus one long hold-off on request
    initial
    begin : rsp_side
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_bus.ready = 1'b0;
            end
            else
                rsp_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // every response transaction is matched against the oldest prediction
    always @(posedge clk)
    begin : rsp_check
        response_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with none outstanding, expected nothing, got %h %h %h",
                         $time, rsp_bus.status, rsp_bus.value_out, rsp_bus.slot_index);
                n_errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                n_checked++;
                n_status[want.status]++;
                check_field("status", 64'(want.status), 64'(rsp_bus.status));
                check_field("value_out", want.value, rsp_bus.value_out);
                check_field("slot_index", 64'(want.slot), 64'(rsp_bus.slot_index));
            end
        end
    end

    initial
    begin : stimulus
        req_bus.valid     = 1'b0;
        req_bus.func      = FUNC_PUT;
        req_bus.key_hash  = '0;
        req_bus.key_bytes = '0;
        req_bus.key_len   = '0;
        req_bus.value_in  = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        send_idle_pct     = 19;
        recv_idle_pct     = 50;
        hold_token        = 0;
        cluster_base      = '0;
        n_requests        = 0;
        n_checked         = 0;
        n_errors          = 0;
        n_cfg_writes      = 0;
        foreach (n_status[i])
            n_status[i] = 0;
        clear_shadow(CAP_IN_W'(TABLE_DEPTH));

        // directed rows at the reset capacity of 1024
        // empty table, then the undecoded func with every field at its top
        req_row(1'b1, FUNC_GET, 32'h0, 64'd0, 4'd0, 64'd0, ST_MISSING, 64'd0, 10'd0);
        req_row(1'b1, FUNC_BAD, 32'hFFFF_FFFF, ONES, 4'd15, ONES, ST_MISSING, 64'd0, 10'd0);
        // lowest hash homes on slot zero, highest on the last slot
        req_row(1'b1, FUNC_PUT, 32'h0, 64'd0, 4'd0, ONES, ST_OK, 64'd0, 10'd0);
        req_row(1'b1, FUNC_GET, 32'h0, 64'd0, 4'd0, 64'd0, ST_OK, ONES, 10'd0);
        req_row(1'b1, FUNC_PUT, 32'hFFFF_FFFF, ONES, 4'd8, 64'd0, ST_OK, 64'd0, 10'd1023);
        // same hash, other key: walks off the end and wraps past slot zero
        req_row(1'b0, FUNC_PUT, 32'hFFFF_FFFF, 64'd0, 4'd8, 64'h0123_4567_89AB_CDEF,
                ST_OK, 64'd0, 10'd0);
        // key length past the key width: lengths must agree exactly
        req_row(1'b0, FUNC_PUT, 32'h8000_0000, 64'h00FF, 4'd15, 64'hA5A5_5A5A_0F0F_F0F0,
                ST_OK, 64'd0, 10'd0);
        req_row(1'b1, FUNC_GET, 32'h8000_0000, 64'h00FF, 4'd9, 64'd0, ST_MISSING, 64'd0, 10'd0);
        req_row(1'b0, FUNC_GET, 32'h8000_0000, 64'h00FF, 4'd15, 64'd0, ST_OK, 64'd0, 10'd0);
        // overwrite of a present key keeps its slot
        req_row(1'b0, FUNC_PUT, 32'h0, 64'd0, 4'd0, 64'h5555_AAAA_5555_AAAA, ST_OK, 64'd0, 10'd0);
        // remove leaves a tombstone that lookups walk past
        req_row(1'b1, FUNC_REMOVE, 32'hFFFF_FFFF, ONES, 4'd8, 64'd0, ST_OK, 64'd0, 10'd1023);
        req_row(1'b1, FUNC_GET, 32'hFFFF_FFFF, ONES, 4'd8, 64'd0, ST_MISSING, 64'd0, 10'd0);
        req_row(1'b0, FUNC_GET, 32'hFFFF_FFFF, 64'd0, 4'd8, 64'd0, ST_OK, 64'd0, 10'd0);
        // a new key takes the tombstone
        req_row(1'b0, FUNC_PUT, 32'hFFFF_FFFF, 64'h1234, 4'd2, 64'h0BAD_F00D, ST_OK, 64'd0, 10'd0);
        // no slots at all
        cfg_row(11'd0);
        req_row(1'b1, FUNC_PUT, 32'h1234_5678, 64'd7, 4'd1, 64'd9, ST_FULL, 64'd0, 10'd0);
        req_row(1'b1, FUNC_GET, 32'h1234_5678, 64'd7, 4'd1, 64'd0, ST_MISSING, 64'd0, 10'd0);
        req_row(1'b1, FUNC_REMOVE, 32'h1234_5678, 64'd7, 4'd1, 64'd0, ST_MISSING, 64'd0, 10'd0);
        // register maximum saturates to the depth and the table starts empty
        cfg_row(11'd2047);
        req_row(1'b1, FUNC_GET, 32'h0, 64'd0, 4'd0, 64'd0, ST_MISSING, 64'd0, 10'd0);
        // four slots: three puts fit, then the load limit answers full
        cfg_row(11'd4);
        req_row(1'b0, FUNC_PUT, 32'h4000_0000, 64'h01, 4'd1, 64'd11, ST_OK, 64'd0, 10'd0);
        req_row(1'b0, FUNC_PUT, 32'h4000_0001, 64'h02, 4'd1, 64'd22, ST_OK, 64'd0, 10'd0);
        req_row(1'b0, FUNC_PUT, 32'hC000_0000, 64'h03, 4'd1, 64'd33, ST_OK, 64'd0, 10'd0);
        req_row(1'b1, FUNC_PUT, 32'h0, 64'h04, 4'd1, 64'd44, ST_FULL, 64'd0, 10'd0);
        // at the limit even a present key is refused
        req_row(1'b1, FUNC_PUT, 32'h4000_0000, 64'h01, 4'd1, 64'd55, ST_FULL, 64'd0, 10'd0);
        req_row(1'b1, FUNC_REMOVE, 32'h4000_0000, 64'h01, 4'd1, 64'd0, ST_OK, 64'd0, 10'd1);
        req_row(1'b0, FUNC_GET, 32'h4000_0001, 64'h02, 4'd1, 64'd0, ST_OK, 64'd0, 10'd0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // the block clears its store after reset; the first transaction
        // simply waits for ready
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_cap)
                write_capacity(directed_rows[i].cap);
            else
                send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each on a freshly cleared table
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_capacity(PHASE_CAP[p]);
            // sender light and receiver heavy, then swapped, then no idling
            if (p == 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 19;
            end
            if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // long receiver hold-off while requests keep coming
                hold_token++;
            end
            cluster_base = 8'($urandom);
            key_pool.delete();
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_request(random_request(), 1'b0, '0);
        end
        req_bus.valid = 1'b0;

        // drain, then give any stray transaction time to show up
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests over %0d capacity writes: %0d ok, %0d not found, %0d full",
                 n_requests, n_cfg_writes, n_status[ST_OK], n_status[ST_MISSING],
                 n_status[ST_FULL]);
        $display("%0d responses checked field by field, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("tb_linear_probe_hash_table passed");
        else
            $display("tb_linear_probe_hash_table failed");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_linear_probe_hash_table failed");
        $finish;
    end

endmodule
